@@ design/quad_keypoint_features_top_macros.svh @@
// assertion helpers shared by the checker
`ifndef QUAD_KEYPOINT_FEATURES_TOP_MACROS_SVH
`define QUAD_KEYPOINT_FEATURES_TOP_MACROS_SVH

// same-cycle implication, off while reset is held
`define QKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is held
`define QKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/qkf_pkg.sv @@
package qkf_pkg;

  localparam int IN_W              = 16;
  localparam int COORD_BITS        = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int NLANE             = 3;
  localparam int LANE_ROLL         = 0;
  localparam int LANE_LEFT         = 1;
  localparam int LANE_RIGHT        = 2;

  localparam int DIV_BITS      = 32;
  localparam int ROOT_BITS     = 16;
  localparam int FRAC_BITS     = 16;
  localparam int SQ_W          = 2 * (COORD_BITS + 1);
  localparam int DSQ_W         = SQ_W + 1;
  localparam int VW            = COORD_BITS + 2;
  localparam int VEC_SHIFT     = 32;
  localparam int XW            = VW + VEC_SHIFT + 3;
  localparam int ZW            = 34;
  localparam int EW            = 36;
  localparam int ANG_Q12_SHIFT = 18;
  localparam int SKEW_W        = 15;
  localparam int RATIO_W       = 16;
  localparam int OUT_W         = 16;

  localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic [RATIO_W-1:0]   RATIO_MAX = '1;
  localparam logic [SKEW_W-1:0]    SKEW_MAX  = '1;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,
    30'd63,        30'd31,        30'd15,        30'd7,
    30'd3,         30'd1,         30'd0,         30'd0
  };

  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [DSQ_W-1:0]    wsq;
    logic [DSQ_W-1:0]    rem;
    logic [DIV_BITS-1:0] nq;
  } div_t;

  typedef struct packed {
    logic [ROOT_BITS+1:0] rem;
    logic [ROOT_BITS-1:0] root;
    logic [DIV_BITS-1:0]  n;
  } root_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic                    degen;
    logic                    force_max;
  } side_t;

  typedef struct packed {
    side_t                  side;
    div_t                   dv;
    cord_t [NLANE-1:0]      lane;
  } front_t;

endpackage

@@ design/qkf_front.sv @@
module qkf_front import qkf_pkg::*; (
  input  logic                   clk,
  input  logic                   adv,
  input  logic signed [IN_W-1:0] in_x [4],
  input  logic signed [IN_W-1:0] in_y [4],
  input  logic signed [IN_W-1:0] off_x,
  input  logic signed [IN_W-1:0] off_y,
  output front_t                 f_out
);

  localparam logic signed [IN_W:0] SUM_HI = (IN_W+1)'((1 << (COORD_BITS-1)) - 1);
  localparam logic signed [IN_W:0] SUM_LO = (IN_W+1)'(-(1 << (COORD_BITS-1)));

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [IN_W:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > SUM_HI) r = SUM_HI[COORD_BITS-1:0];
    else if (v < SUM_LO) r = SUM_LO[COORD_BITS-1:0];
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [COORD_BITS:0] cdiff(input logic signed [COORD_BITS-1:0] a,
                                                      input logic signed [COORD_BITS-1:0] b);
    return $signed((COORD_BITS+1)'(a)) - $signed((COORD_BITS+1)'(b));
  endfunction

  // stage 1: offset and saturate
  logic signed [IN_W:0]         sum_x [4];
  logic signed [IN_W:0]         sum_y [4];
  logic signed [COORD_BITS-1:0] px_r [4];
  logic signed [COORD_BITS-1:0] py_r [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_x[k] = $signed({in_x[k][IN_W-1], in_x[k]}) + $signed({off_x[IN_W-1], off_x});
      sum_y[k] = $signed({in_y[k][IN_W-1], in_y[k]}) + $signed({off_y[IN_W-1], off_y});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        px_r[k] <= sat_coord(sum_x[k]);
        py_r[k] <= sat_coord(sum_y[k]);
      end
    end
  end

  // stage 2: edge squares, center, angle vectors
  // edges: 0 = c0-c3, 1 = c1-c2 (vertical), 2 = c0-c1, 3 = c3-c2 (horizontal)
  logic signed [COORD_BITS:0]   ex [4];
  logic signed [COORD_BITS:0]   ey [4];
  logic signed [SQ_W-1:0]       pxx [4];
  logic signed [SQ_W-1:0]       pyy [4];
  logic signed [COORD_BITS+1:0] csum_x, csum_y;
  logic signed [VW-1:0]         vx [NLANE];
  logic signed [VW-1:0]         vy [NLANE];
  logic [SQ_W-1:0]              sqx_r [4];
  logic [SQ_W-1:0]              sqy_r [4];
  logic signed [OUT_W-1:0]      cx_r, cy_r;
  logic signed [VW-1:0]         vx_r [NLANE];
  logic signed [VW-1:0]         vy_r [NLANE];

  always_comb begin
    ex[0] = cdiff(px_r[0], px_r[3]);
    ey[0] = cdiff(py_r[0], py_r[3]);
    ex[1] = cdiff(px_r[1], px_r[2]);
    ey[1] = cdiff(py_r[1], py_r[2]);
    ex[2] = cdiff(px_r[0], px_r[1]);
    ey[2] = cdiff(py_r[0], py_r[1]);
    ex[3] = cdiff(px_r[3], px_r[2]);
    ey[3] = cdiff(py_r[3], py_r[2]);
    for (int k = 0; k < 4; k++) begin
      pxx[k] = ex[k] * ex[k];
      pyy[k] = ey[k] * ey[k];
    end
    csum_x = $signed((COORD_BITS+2)'(px_r[0])) + $signed((COORD_BITS+2)'(px_r[1]))
           + $signed((COORD_BITS+2)'(px_r[2])) + $signed((COORD_BITS+2)'(px_r[3]));
    csum_y = $signed((COORD_BITS+2)'(py_r[0])) + $signed((COORD_BITS+2)'(py_r[1]))
           + $signed((COORD_BITS+2)'(py_r[2])) + $signed((COORD_BITS+2)'(py_r[3]));
    vx[LANE_ROLL] = ($signed(VW'(px_r[1])) + $signed(VW'(px_r[2])))
                  - ($signed(VW'(px_r[0])) + $signed(VW'(px_r[3])));
    vy[LANE_ROLL] = ($signed(VW'(py_r[1])) + $signed(VW'(py_r[2])))
                  - ($signed(VW'(py_r[0])) + $signed(VW'(py_r[3])));
    vx[LANE_LEFT]  = $signed(VW'(cdiff(px_r[3], px_r[0])));
    vy[LANE_LEFT]  = $signed(VW'(cdiff(py_r[3], py_r[0])));
    vx[LANE_RIGHT] = $signed(VW'(cdiff(px_r[2], px_r[1])));
    vy[LANE_RIGHT] = $signed(VW'(cdiff(py_r[2], py_r[1])));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        sqx_r[k] <= pxx[k];
        sqy_r[k] <= pyy[k];
      end
      // floor divide by four
      cx_r <= OUT_W'(csum_x[COORD_BITS+1:2]);
      cy_r <= OUT_W'(csum_y[COORD_BITS+1:2]);
      for (int l = 0; l < NLANE; l++) begin
        vx_r[l] <= vx[l];
        vy_r[l] <= vy[l];
      end
    end
  end

  // stage 3: lengths, divider seed, cordic pre-rotation
  logic [DSQ_W-1:0]           dsq [4];
  logic [DSQ_W-1:0]           wsq, lsq;
  logic [DSQ_W+FRAC_BITS-1:0] num;
  logic signed [VW:0]         nx, ny;
  front_t                     f_nxt;
  front_t                     f_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dsq[k] = DSQ_W'(sqx_r[k]) + DSQ_W'(sqy_r[k]);
    end
    wsq = (dsq[0] > dsq[1]) ? dsq[0] : dsq[1];
    lsq = (dsq[2] > dsq[3]) ? dsq[2] : dsq[3];
    num = {lsq, {FRAC_BITS{1'b0}}};

    f_nxt.side.center_x  = cx_r;
    f_nxt.side.center_y  = cy_r;
    f_nxt.side.degen     = (wsq == '0);
    // quotient at or above 2^DIV_BITS gives a root past the output range
    f_nxt.side.force_max = (wsq == '0) ||
                           ({{FRAC_BITS{1'b0}}, lsq} >= {wsq, {FRAC_BITS{1'b0}}});
    f_nxt.dv.wsq = wsq;
    f_nxt.dv.rem = DSQ_W'(num >> DIV_BITS);
    f_nxt.dv.nq  = num[DIV_BITS-1:0];

    for (int l = 0; l < NLANE; l++) begin
      f_nxt.lane[l].zero = (vx_r[l] == '0) && (vy_r[l] == '0);
      if (vx_r[l][VW-1]) begin
        if (!vy_r[l][VW-1]) begin
          nx = $signed((VW+1)'(vy_r[l]));
          ny = -$signed((VW+1)'(vx_r[l]));
          f_nxt.lane[l].z = HALF_PI;
        end else begin
          nx = -$signed((VW+1)'(vy_r[l]));
          ny = $signed((VW+1)'(vx_r[l]));
          f_nxt.lane[l].z = -HALF_PI;
        end
      end else begin
        nx = $signed((VW+1)'(vx_r[l]));
        ny = $signed((VW+1)'(vy_r[l]));
        f_nxt.lane[l].z = '0;
      end
      f_nxt.lane[l].x = XW'($signed({nx, {VEC_SHIFT{1'b0}}}));
      f_nxt.lane[l].y = XW'($signed({ny, {VEC_SHIFT{1'b0}}}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r <= f_nxt;
    end
  end

  assign f_out = f_r;

endmodule

@@ design/qkf_cordic_cell.sv @@
module qkf_cordic_cell import qkf_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  adv,
  input  cord_t c_in,
  output cord_t c_out
);

  logic signed [XW-1:0] x, y, xs, ys;
  logic signed [ZW-1:0] z, at;
  cord_t                c_nxt;
  cord_t                c_r;

  always_comb begin
    x  = c_in.x;
    y  = c_in.y;
    z  = c_in.z;
    xs = x >>> STAGE;
    ys = y >>> STAGE;
    at = $signed({{(ZW-30){1'b0}}, ATAN_TAB[STAGE]});
    c_nxt.zero = c_in.zero;
    if (!y[XW-1]) begin
      c_nxt.x = x + ys;
      c_nxt.y = y - xs;
      c_nxt.z = z + at;
    end else begin
      c_nxt.x = x - ys;
      c_nxt.y = y + xs;
      c_nxt.z = z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

@@ design/qkf_div_cell.sv @@
module qkf_div_cell import qkf_pkg::*; (
  input  logic clk,
  input  logic adv,
  input  div_t d_in,
  output div_t d_out
);

  logic [DSQ_W:0] trial;
  logic           take;
  div_t           d_nxt;
  div_t           d_r;

  // one restoring step: bring down the next numerator bit, quotient bit shifts in
  always_comb begin
    trial       = {d_in.rem, d_in.nq[DIV_BITS-1]};
    take        = (trial >= {1'b0, d_in.wsq});
    d_nxt.wsq   = d_in.wsq;
    d_nxt.rem   = take ? DSQ_W'(trial - {1'b0, d_in.wsq}) : trial[DSQ_W-1:0];
    d_nxt.nq    = {d_in.nq[DIV_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

@@ design/qkf_sqrt_cell.sv @@
module qkf_sqrt_cell import qkf_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  root_t r_in,
  output root_t r_out
);

  logic [ROOT_BITS+3:0] trial, test;
  logic                 take;
  root_t                r_nxt;
  root_t                r_r;

  // one root bit per cell, two radicand bits consumed
  always_comb begin
    trial      = {r_in.rem, r_in.n[DIV_BITS-1 -: 2]};
    test       = {2'b00, r_in.root, 2'b01};
    take       = (trial >= test);
    r_nxt.rem  = take ? (ROOT_BITS+2)'(trial - test) : trial[ROOT_BITS+1:0];
    r_nxt.root = {r_in.root[ROOT_BITS-2:0], take};
    r_nxt.n    = {r_in.n[DIV_BITS-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r <= r_nxt;
    end
  end

  assign r_out = r_r;

endmodule

@@ design/quad_keypoint_features_top.sv @@
// Quadrilateral keypoint features.
// Input channel: one beat carries four corners and a region offset (signed,
// pixels times 16). Output channel: one beat per input beat with the center,
// the Q8.8 aspect ratio, the Q3.12 skew error and the degenerate flag.
// Both channels are valid/stall; a beat moves when valid is high and stall low.
// From input beat to output valid the path runs through three front stages,
// 32 divider cells (one quotient bit each), 16 square-root cells (one root bit
// each) and the output register. The CORDIC lanes run CORDIC_STAGES cells
// alongside the divider and are delay-matched to the divider and root chain.
// Throughput is one beat per cycle unless stalled; every stage advances together.
// When out_stall is high while a result is held, the whole chain freezes and
// in_stall goes high in the same cycle; with no result held, input keeps flowing.
// Reset clears all valid bits; data in flight is dropped, out_valid is low.
module quad_keypoint_features_top import qkf_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   in_corner0_x,
  input  logic signed [IN_W-1:0]   in_corner0_y,
  input  logic signed [IN_W-1:0]   in_corner1_x,
  input  logic signed [IN_W-1:0]   in_corner1_y,
  input  logic signed [IN_W-1:0]   in_corner2_x,
  input  logic signed [IN_W-1:0]   in_corner2_y,
  input  logic signed [IN_W-1:0]   in_corner3_x,
  input  logic signed [IN_W-1:0]   in_corner3_y,
  input  logic signed [IN_W-1:0]   in_offset_x,
  input  logic signed [IN_W-1:0]   in_offset_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  out_center_x,
  output logic signed [OUT_W-1:0]  out_center_y,
  output logic [RATIO_W-1:0]       out_aspect_ratio,
  output logic [SKEW_W-1:0]        out_skew_error,
  output logic                     out_degenerate
);

  localparam int CHAIN    = DIV_BITS + ROOT_BITS;
  localparam int NST      = 3 + CHAIN;
  localparam int SKEW_DLY = CHAIN - CORDIC_STAGES - 1;

  logic                    adv;
  logic                    out_valid_r;
  logic [NST-1:0]          vld_r;
  logic signed [IN_W-1:0]  cx_in [4];
  logic signed [IN_W-1:0]  cy_in [4];
  front_t                  f;
  div_t                    dv [DIV_BITS+1];
  root_t                   rt [ROOT_BITS+1];
  cord_t                   cr [NLANE][CORDIC_STAGES+1];
  side_t                   side_dly_r [CHAIN];
  logic [SKEW_W-1:0]       skew_nxt;
  logic [SKEW_W-1:0]       skew_r;
  logic [SKEW_W-1:0]       skew_dly_r [SKEW_DLY];
  logic signed [ZW-1:0]    ang [NLANE];
  logic signed [EW-1:0]    el, er;
  logic [EW-1:0]           al, ar, amax;
  logic signed [OUT_W-1:0] center_x_r, center_y_r;
  logic [RATIO_W-1:0]      ratio_r;
  logic [SKEW_W-1:0]       skew_out_r;
  logic                    degen_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  assign cx_in[0] = in_corner0_x;
  assign cy_in[0] = in_corner0_y;
  assign cx_in[1] = in_corner1_x;
  assign cy_in[1] = in_corner1_y;
  assign cx_in[2] = in_corner2_x;
  assign cy_in[2] = in_corner2_y;
  assign cx_in[3] = in_corner3_x;
  assign cy_in[3] = in_corner3_y;

  qkf_front u_front (
    .clk   (clk),
    .adv   (adv),
    .in_x  (cx_in),
    .in_y  (cy_in),
    .off_x (in_offset_x),
    .off_y (in_offset_y),
    .f_out (f)
  );

  // ratio path: divider cells then square-root cells
  assign dv[0] = f.dv;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    qkf_div_cell u_cell (.clk(clk), .adv(adv), .d_in(dv[i]), .d_out(dv[i+1]));
  end

  assign rt[0].rem  = '0;
  assign rt[0].root = '0;
  assign rt[0].n    = dv[DIV_BITS].nq;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
    qkf_sqrt_cell u_cell (.clk(clk), .adv(adv), .r_in(rt[i]), .r_out(rt[i+1]));
  end

  // angle path: three cordic lanes
  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    assign cr[l][0] = f.lane[l];
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      qkf_cordic_cell #(.STAGE(s)) u_cell (
        .clk   (clk),
        .adv   (adv),
        .c_in  (cr[l][s]),
        .c_out (cr[l][s+1])
      );
    end
    assign ang[l] = cr[l][CORDIC_STAGES].zero ? '0 : cr[l][CORDIC_STAGES].z;
  end

  always_comb begin
    el   = $signed(EW'(ang[LANE_LEFT])) - $signed(EW'(ang[LANE_ROLL]))
         - $signed(EW'(HALF_PI));
    er   = $signed(EW'(ang[LANE_RIGHT])) - $signed(EW'(ang[LANE_ROLL]))
         - $signed(EW'(HALF_PI));
    al   = el[EW-1] ? EW'(-el) : EW'(el);
    ar   = er[EW-1] ? EW'(-er) : EW'(er);
    amax = (ar > al) ? ar : al;
    if (|amax[EW-1:ANG_Q12_SHIFT+SKEW_W]) skew_nxt = SKEW_MAX;
    else skew_nxt = amax[ANG_Q12_SHIFT +: SKEW_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      skew_r        <= skew_nxt;
      skew_dly_r[0] <= skew_r;
      for (int k = 1; k < SKEW_DLY; k++) begin
        skew_dly_r[k] <= skew_dly_r[k-1];
      end
      side_dly_r[0] <= f.side;
      for (int k = 1; k < CHAIN; k++) begin
        side_dly_r[k] <= side_dly_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      center_x_r <= side_dly_r[CHAIN-1].center_x;
      center_y_r <= side_dly_r[CHAIN-1].center_y;
      degen_r    <= side_dly_r[CHAIN-1].degen;
      ratio_r    <= side_dly_r[CHAIN-1].force_max ? RATIO_MAX : rt[ROOT_BITS].root;
      skew_out_r <= skew_dly_r[SKEW_DLY-1];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_center_x     = center_x_r;
  assign out_center_y     = center_y_r;
  assign out_aspect_ratio = ratio_r;
  assign out_skew_error   = skew_out_r;
  assign out_degenerate   = degen_r;

endmodule

@@ design/qkf_checker.sv @@
`include "quad_keypoint_features_top_macros.svh"

module qkf_checker import qkf_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] out_center_x,
  input logic [RATIO_W-1:0]      out_aspect_ratio,
  input logic                    out_degenerate
);

  `QKF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped under stall")
  `QKF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_center_x) && $stable(out_aspect_ratio), "stalled result changed")
  `QKF_ASSERT_NOW(a_degen_ratio, out_valid && out_degenerate, out_aspect_ratio == RATIO_MAX, "degenerate beat without saturated ratio")
  `QKF_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind quad_keypoint_features_top qkf_checker u_qkf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_center_x     (out_center_x),
  .out_aspect_ratio (out_aspect_ratio),
  .out_degenerate   (out_degenerate)
);
